@@ design/iso_dir_pkg.sv @@
package iso_dir_pkg;

	localparam int SECTOR_BYTES = 2048;
	localparam int IDX_W = 6;

	localparam logic [7:0] MIN_RECORD = 8'd34;
	localparam logic [7:0] FLAGS_AT = 8'd25;
	localparam logic [7:0] NAME_LEN_AT = 8'd32;
	localparam logic [7:0] NAME_AT = 8'd33;
	localparam logic [15:0] TAG_NM = 16'h4E4D;
	localparam logic [7:0] NM_FLAG_MASK = 8'h06;
	localparam logic [7:0] CHAR_SEMI = 8'h3B;
	localparam logic [7:0] CHAR_DOT = 8'h2E;

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_COPY = 2'd1;
	localparam logic [1:0] PH_FOUND = 2'd2;
	localparam logic [1:0] PH_NONE = 2'd3;

	localparam logic [1:0] KIND_ORDINARY = 2'd0;

	localparam logic [2:0] REG_SKIP_ADDR = 3'd0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic sector_end;
	} in_t;

	typedef struct packed {
		logic [31:0] extent_block;
		logic [31:0] data_length;
		logic is_directory;
		logic [1:0] entry_kind;
		logic from_extension;
		logic [7:0] name_char;
		logic char_valid;
		logic last;
	} out_t;

	// one finished record waiting for its name burst
	typedef struct packed {
		logic [31:0] extent_block;
		logic [31:0] data_length;
		logic is_directory;
		logic [1:0] entry_kind;
		logic from_extension;
		logic [IDX_W-1:0] char_cnt;
		logic slot;
	} desc_t;

	typedef struct packed {
		logic en;
		logic ext;
		logic slot;
		logic [IDX_W-1:0] idx;
		logic [7:0] data;
	} name_wr_t;

endpackage

@@ design/iso_dir_front.sv @@
module iso_dir_front #(
	parameter int NAME_CAP = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input iso_dir_pkg::in_t in_data,
	input logic skip_self_parent,
	input logic queue_full,
	output logic push,
	output iso_dir_pkg::desc_t push_desc,
	output iso_dir_pkg::name_wr_t name_wr
);
	import iso_dir_pkg::*;

	localparam int CW = $clog2(NAME_CAP);
	localparam logic [CW-1:0] KEEP = CW'(NAME_CAP - 1);

	logic [10:0] off_q, n_off;
	logic [7:0] rlen_q, n_rlen;
	logic [7:0] pos_q, n_pos;
	logic skip_q, n_skip;
	logic [7:0] pnl_q, n_pnl;
	logic [7:0] fnb_q, n_fnb;
	logic [31:0] ext_q, n_ext;
	logic [31:0] size_q, n_size;
	logic [7:0] flags_q, n_flags;
	logic [CW-1:0] pcount_q, n_pcount;
	logic [CW-1:0] pkept_q, n_pkept;
	logic stopped_q, n_stopped;
	logic [CW-1:0] ecount_q, n_ecount;
	logic [7:0] fs_q, n_fs;
	logic [7:0] fl_q, n_fl;
	logic [15:0] tag_q, n_tag;
	logic [1:0] phase_q, n_phase;
	logic slot_q;

	logic acc;
	logic [7:0] b;
	logic [7:0] p;
	logic [7:0] d;
	logic [9:0] start;
	logic [9:0] fend;
	logic [7:0] lc;
	logic [1:0] kind;
	logic fromext;

	assign in_ready = !queue_full;
	assign acc = in_valid && in_ready;
	assign b = in_data.data_byte;
	assign p = pos_q;

	always_comb begin
		n_off = off_q; n_rlen = rlen_q; n_pos = pos_q; n_skip = skip_q;
		n_pnl = pnl_q; n_fnb = fnb_q; n_ext = ext_q; n_size = size_q;
		n_flags = flags_q; n_pcount = pcount_q; n_pkept = pkept_q;
		n_stopped = stopped_q; n_ecount = ecount_q; n_fs = fs_q; n_fl = fl_q;
		n_tag = tag_q; n_phase = phase_q;
		push = 1'b0;
		push_desc = '0;
		name_wr = '0;
		d = p - fs_q;
		start = 10'd33 + {2'b0, b} + {9'b0, ~b[0]};
		fend = {2'b0, fs_q} + {2'b0, fl_q};
		lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
		kind = KIND_ORDINARY;
		fromext = 1'b0;
		if (acc) begin
			if (!skip_q) begin
				if (pos_q == 8'd0) begin
					if (b == 8'd0 || ({1'b0, off_q} + {4'b0, b}) > 12'(SECTOR_BYTES)) begin
						n_skip = 1'b1;
					end else begin
						n_rlen = b; n_pnl = '0; n_fnb = '0; n_ext = '0; n_size = '0;
						n_flags = '0; n_pcount = '0; n_pkept = '0; n_stopped = 1'b0;
						n_ecount = '0; n_fs = '0; n_fl = '0; n_tag = '0;
						n_phase = PH_NONE;
						n_pos = (b > 8'd1) ? 8'd1 : 8'd0;
					end
				end else begin
					if (p >= 8'd2 && p <= 8'd5)
						n_ext = {b, ext_q[31:8]};
					if (p >= 8'd10 && p <= 8'd13)
						n_size = {b, size_q[31:8]};
					if (p == FLAGS_AT)
						n_flags = b;
					if (p == NAME_LEN_AT) begin
						n_pnl = b;
						if (start + 10'd4 > {2'b0, rlen_q}) begin
							n_phase = PH_NONE;
						end else begin
							n_fs = start[7:0];
							n_phase = PH_SEARCH;
						end
					end
					if (p == NAME_AT)
						n_fnb = b;
					if (p >= NAME_AT && {1'b0, p} < {1'b0, NAME_AT} + {1'b0, pnl_q}
							&& !stopped_q) begin
						if (b == CHAR_SEMI) begin
							n_stopped = 1'b1;
						end else if (pcount_q < KEEP) begin
							name_wr.en = 1'b1;
							name_wr.ext = 1'b0;
							name_wr.slot = slot_q;
							name_wr.idx = IDX_W'(pcount_q);
							name_wr.data = lc;
							n_pcount = pcount_q + 1'b1;
							if (lc != CHAR_DOT)
								n_pkept = pcount_q + 1'b1;
						end
					end
					if (p > NAME_LEN_AT) begin
						if (phase_q == PH_SEARCH) begin
							if (p >= fs_q) begin
								case (d)
									8'd0: n_tag = {b, 8'h00};
									8'd1: n_tag = tag_q | {8'h00, b};
									8'd2: begin
										n_fl = b;
										if (b < 8'd4 || ({1'b0, fs_q} + {1'b0, b}) > {1'b0, rlen_q})
											n_phase = PH_NONE;
									end
									8'd3: begin
										if (!(tag_q == TAG_NM && fl_q >= 8'd5)) begin
											if (fend + 10'd4 > {2'b0, rlen_q})
												n_phase = PH_NONE;
											else
												n_fs = fend[7:0];
										end
									end
									8'd4: begin
										if ((b & NM_FLAG_MASK) != 8'd0)
											n_phase = PH_NONE;
										else if (fl_q == 8'd5)
											n_phase = PH_FOUND;
										else
											n_phase = PH_COPY;
									end
									default: ;
								endcase
							end
						end else if (phase_q == PH_COPY) begin
							if ({2'b0, p} < fend) begin
								if (ecount_q < KEEP) begin
									name_wr.en = 1'b1;
									name_wr.ext = 1'b1;
									name_wr.slot = slot_q;
									name_wr.idx = IDX_W'(ecount_q);
									name_wr.data = b;
									n_ecount = ecount_q + 1'b1;
								end
								if ({2'b0, p} + 10'd1 == fend)
									n_phase = PH_FOUND;
							end
						end
					end
					if ({1'b0, p} + 9'd1 >= {1'b0, rlen_q}) begin
						n_pos = 8'd0;
						if (rlen_q >= MIN_RECORD) begin
							if (n_pnl == 8'd1 && n_fnb <= 8'd1)
								kind = n_fnb[1:0] + 2'd1;
							fromext = (n_phase == PH_FOUND) && (n_ecount != '0);
							push_desc.extent_block = n_ext;
							push_desc.data_length = n_size;
							push_desc.is_directory = n_flags[1];
							push_desc.entry_kind = kind;
							push_desc.slot = slot_q;
							if (kind != KIND_ORDINARY) begin
								push = !skip_self_parent;
							end else begin
								push = 1'b1;
								push_desc.from_extension = fromext;
								push_desc.char_cnt = fromext ? IDX_W'(n_ecount) : IDX_W'(n_pkept);
							end
						end
					end else begin
						n_pos = p + 8'd1;
					end
				end
			end
			if (in_data.sector_end || off_q >= 11'(SECTOR_BYTES - 1)) begin
				n_off = '0;
				n_pos = 8'd0;
				n_skip = 1'b0;
			end else begin
				n_off = off_q + 11'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0; rlen_q <= '0; pos_q <= '0; skip_q <= 1'b0;
			pnl_q <= '0; fnb_q <= '0; ext_q <= '0; size_q <= '0; flags_q <= '0;
			pcount_q <= '0; pkept_q <= '0; stopped_q <= 1'b0; ecount_q <= '0;
			fs_q <= '0; fl_q <= '0; tag_q <= '0; phase_q <= PH_SEARCH;
			slot_q <= 1'b0;
		end else begin
			off_q <= n_off; rlen_q <= n_rlen; pos_q <= n_pos; skip_q <= n_skip;
			pnl_q <= n_pnl; fnb_q <= n_fnb; ext_q <= n_ext; size_q <= n_size;
			flags_q <= n_flags; pcount_q <= n_pcount; pkept_q <= n_pkept;
			stopped_q <= n_stopped; ecount_q <= n_ecount; fs_q <= n_fs;
			fl_q <= n_fl; tag_q <= n_tag; phase_q <= n_phase;
			if (push)
				slot_q <= !slot_q;
		end
	end

endmodule

@@ design/iso_dir_queue.sv @@
module iso_dir_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input iso_dir_pkg::desc_t push_desc,
	input logic pop,
	output logic full,
	output logic head_valid,
	output iso_dir_pkg::desc_t head
);
	import iso_dir_pkg::*;

	desc_t entry_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ design/iso_dir_back.sv @@
module iso_dir_back #(
	parameter int NAME_CAP = 32
) (
	input logic clk,
	input logic arst_n,
	input iso_dir_pkg::name_wr_t name_wr,
	input logic head_valid,
	input iso_dir_pkg::desc_t head,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output iso_dir_pkg::out_t out_data
);
	import iso_dir_pkg::*;

	localparam int CW = $clog2(NAME_CAP);
	localparam int AW = CW + 2;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_RD = 2'd1;
	localparam logic [1:0] B_OUT = 2'd2;

	logic [7:0] name_mem [2**AW];
	logic [7:0] rd_q;
	logic [1:0] state_q;
	logic [CW-1:0] idx_q;
	logic no_chars;
	logic is_last;
	logic out_acc;
	logic [AW-1:0] raddr;

	assign no_chars = (head.entry_kind != KIND_ORDINARY) || (head.char_cnt == '0);
	assign is_last = no_chars || ({1'b0, idx_q} + 1'b1 == (CW+1)'(head.char_cnt));
	assign out_valid = (state_q == B_OUT);
	assign out_acc = out_valid && out_ready;
	assign pop = out_acc && is_last;
	assign raddr = {head.from_extension, head.slot, idx_q};

	always_ff @(posedge clk) begin
		if (name_wr.en)
			name_mem[{name_wr.ext, name_wr.slot, name_wr.idx[CW-1:0]}] <= name_wr.data;
		if (state_q == B_RD)
			rd_q <= name_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					idx_q <= '0;
					if (head_valid)
						state_q <= no_chars ? B_OUT : B_RD;
				end
				B_RD: state_q <= B_OUT;
				B_OUT: begin
					if (out_acc) begin
						if (is_last) begin
							state_q <= B_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= B_RD;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_comb begin
		out_data.extent_block = head.extent_block;
		out_data.data_length = head.data_length;
		out_data.is_directory = head.is_directory;
		out_data.entry_kind = head.entry_kind;
		out_data.from_extension = head.from_extension;
		out_data.char_valid = !no_chars;
		out_data.name_char = no_chars ? 8'd0 : rd_q;
		out_data.last = is_last;
	end

`ifndef ASSERT_OFF
	a_out_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> head_valid) else $error("result shown with empty queue");
	a_read_then_show: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RD) |=> out_valid) else $error("read not followed by result");
	a_next_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !is_last) |=> (state_q == B_RD))
		else $error("burst did not continue");
`endif

endmodule

@@ design/iso_directory_record_parser_core.sv @@
// Once a record's last byte is accepted, its entry is registered in the queue; the back
// then goes from idle through a memory read to output (straight to output when the
// result carries no name character). The front takes one sector byte per cycle while
// the queue is not full; the back reads each name character from memory, then outputs it.
// The front holds off bytes while two finished records are still pending.
// Reset: arst_n asynchronous, active low; skip_self_parent resets to 1.
module iso_directory_record_parser_core #(
	parameter int NAME_CAP = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input iso_dir_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output iso_dir_pkg::out_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import iso_dir_pkg::*;

	// mode register: 1 drops self/parent records
	logic skip_q;
	logic cfg_wr;

	logic push, pop, full, head_valid;
	desc_t push_desc, head;
	name_wr_t name_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == REG_SKIP_ADDR) ? {31'd0, skip_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b1;
		end else if (cfg_wr && paddr == REG_SKIP_ADDR) begin
			skip_q <= pwdata[0];
		end
	end

	// front: frames records, collects fields, writes names to the double-buffered store
	iso_dir_front #(.NAME_CAP(NAME_CAP)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.skip_self_parent(skip_q), .queue_full(full),
		.push, .push_desc, .name_wr
	);

	// two-entry request queue; an entry frees only when its burst is done
	iso_dir_queue u_queue (
		.clk, .arst_n, .push, .push_desc, .pop,
		.full, .head_valid, .head
	);

	// back: plays out the name of the head record
	iso_dir_back #(.NAME_CAP(NAME_CAP)) u_back (
		.clk, .arst_n, .name_wr, .head_valid, .head, .pop,
		.out_valid, .out_ready, .out_data
	);

endmodule
